/* rtl/kvt_pkg.sv */
package kvt_pkg;

	localparam int ENTRY_TOTAL_W = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] ST_DONE          = 3'd0;
	localparam logic [2:0] ST_DUPLICATE     = 3'd1;
	localparam logic [2:0] ST_FULL          = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd3;
	localparam logic [2:0] ST_MISS_INSERTED = 3'd4;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] key_in;
		logic [31:0]        value_in;
	} kvt_req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [31:0]              value_out;
		logic [ENTRY_TOTAL_W-1:0] entry_total;
	} kvt_rsp_t;

	typedef struct packed {
		logic       accept;
		logic       step;
		logic       capture;
		logic       shift;
		logic       finish;
		logic       append;
		logic       append_zero;
		logic       dec;
		logic       clr;
		logic [2:0] status;
		logic       use_found;
	} kvt_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       hit;
		logic       exhausted;
		logic       cmp_valid;
		logic       found;
		logic       full;
		logic       out_free;
	} kvt_sts_t;

endpackage

/* rtl/key_value_table.sv */
// Channel | Handshake            | Payload
// req     | req_valid, req_ready | kvt_req_t: op, key_in, value_in
// rsp     | rsp_valid, rsp_ready | kvt_rsp_t: status, value_out, entry_total
//
// One transaction at a time. Entries are scanned one per cycle through a single
// registered memory read port. A remove that hits moves the later entries down
// while the scan goes on; a clear does not scan the entries. Reset clears the
// control state, fill count, read index and valid flags but not the key and value
// memories. A new request is taken while the previous response waits; only the
// final step stalls until the response register is free.
module key_value_table import kvt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  kvt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output kvt_rsp_t rsp
);

	kvt_cmd_t cmd;
	kvt_sts_t sts;

	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kvt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* rtl/kvt_ctrl.sv */
module kvt_ctrl import kvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  kvt_sts_t sts,
	output kvt_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.status = ST_DONE;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.op == OP_CLEAR) begin
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
					if (sts.hit) begin
						cmd.capture = 1'b1;
						state_d = (sts.op == OP_REMOVE) ? S_SHIFT : S_FINISH;
					end else if (sts.exhausted) begin
						cmd.capture = 1'b1;
						state_d     = S_FINISH;
					end
				end
			end
			S_SHIFT: begin
				cmd.step  = 1'b1;
				cmd.shift = 1'b1;
				if (sts.exhausted && !sts.cmp_valid) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
					case (sts.op)
						OP_INSERT: begin
							if (sts.found) begin
								cmd.status = ST_DUPLICATE;
							end else if (sts.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.append = 1'b1;
							end
						end
						OP_LOOKUP: begin
							if (sts.found) begin
								cmd.use_found = 1'b1;
							end else if (sts.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.append      = 1'b1;
								cmd.append_zero = 1'b1;
								cmd.status      = ST_MISS_INSERTED;
							end
						end
						OP_REMOVE: begin
							if (sts.found) begin
								cmd.dec = 1'b1;
							end else begin
								cmd.status = ST_NOT_FOUND;
							end
						end
						default: begin
							cmd.clr = 1'b1;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/kvt_datapath.sv */
module kvt_datapath import kvt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  kvt_req_t req,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	output kvt_rsp_t rsp,
	input  kvt_cmd_t cmd,
	output kvt_sts_t sts
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic [31:0] key_mem [TABLE_DEPTH];
	logic [31:0] value_mem [TABLE_DEPTH];

	logic [1:0]       op_q;
	logic [31:0]      key_q;
	logic [31:0]      value_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;
	logic [CNT_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             cmp_valid_q;
	logic [31:0]      key_rd_q;
	logic [31:0]      value_rd_q;
	logic             found_q;
	logic [31:0]      found_value_q;
	logic             rsp_valid_q;
	kvt_rsp_t         rsp_q;

	logic             issue;
	logic             hit;
	logic             out_free;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [31:0]      mem_wkey;
	logic [31:0]      mem_wvalue;

	assign issue    = cmd.step && (rd_idx_q < fill_q);
	assign hit      = cmp_valid_q && (key_rd_q == key_q);
	assign out_free = !rsp_valid_q || rsp_ready;

	assign mem_we     = (cmd.shift && cmp_valid_q) || (cmd.finish && cmd.append);
	assign mem_waddr  = cmd.append ? fill_q[IDX_W-1:0] : (cmp_idx_q - 1'b1);
	assign mem_wkey   = cmd.append ? key_q : key_rd_q;
	assign mem_wvalue = cmd.append ? (cmd.append_zero ? 32'd0 : value_q) : value_rd_q;

	always_comb begin
		fill_d = fill_q;
		if (cmd.clr) begin
			fill_d = '0;
		end else if (cmd.append) begin
			fill_d = fill_q + 1'b1;
		end else if (cmd.dec) begin
			fill_d = fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr]   <= mem_wkey;
			value_mem[mem_waddr] <= mem_wvalue;
		end
		if (issue) begin
			key_rd_q   <= key_mem[rd_idx_q[IDX_W-1:0]];
			value_rd_q <= value_mem[rd_idx_q[IDX_W-1:0]];
			cmp_idx_q  <= rd_idx_q[IDX_W-1:0];
		end
		if (cmd.accept) begin
			op_q    <= req.op;
			key_q   <= req.key_in;
			value_q <= req.value_in;
		end
		if (cmd.capture) begin
			found_q       <= hit;
			found_value_q <= value_rd_q;
		end
		if (cmd.finish) begin
			rsp_q.status      <= cmd.status;
			rsp_q.value_out   <= cmd.use_found ? found_value_q : 32'd0;
			rsp_q.entry_total <= ENTRY_TOTAL_W'(fill_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_idx_q    <= '0;
			cmp_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				fill_q <= fill_d;
			end
			if (cmd.accept) begin
				rd_idx_q    <= '0;
				cmp_valid_q <= 1'b0;
			end else begin
				cmp_valid_q <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts.op        = op_q;
		sts.hit       = hit;
		sts.exhausted = (rd_idx_q >= fill_q);
		sts.cmp_valid = cmp_valid_q;
		sts.found     = found_q;
		sts.full      = (fill_q == CNT_W'(TABLE_DEPTH));
		sts.out_free  = out_free;
	end

endmodule
